### src/mips64_primary_opcode_execute_macros.svh
// assertion macros for the execute unit
`ifndef MIPS64_PRIMARY_OPCODE_EXECUTE_MACROS_SVH
`define MIPS64_PRIMARY_OPCODE_EXECUTE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MPOE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MPOE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mpoe_pkg.sv
// types and constants shared by the execute unit modules
package mpoe_pkg;

  // primary opcodes
  localparam logic [5:0] OP_J      = 6'h02;
  localparam logic [5:0] OP_JAL    = 6'h03;
  localparam logic [5:0] OP_BEQ    = 6'h04;
  localparam logic [5:0] OP_BNE    = 6'h05;
  localparam logic [5:0] OP_BLEZ   = 6'h06;
  localparam logic [5:0] OP_BGTZ   = 6'h07;
  localparam logic [5:0] OP_ADDIU  = 6'h09;
  localparam logic [5:0] OP_SLTI   = 6'h0A;
  localparam logic [5:0] OP_SLTIU  = 6'h0B;
  localparam logic [5:0] OP_ANDI   = 6'h0C;
  localparam logic [5:0] OP_ORI    = 6'h0D;
  localparam logic [5:0] OP_XORI   = 6'h0E;
  localparam logic [5:0] OP_LUI    = 6'h0F;
  localparam logic [5:0] OP_BEQL   = 6'h14;
  localparam logic [5:0] OP_BNEL   = 6'h15;
  localparam logic [5:0] OP_DADDIU = 6'h19;
  localparam logic [5:0] OP_LDL    = 6'h1A;
  localparam logic [5:0] OP_LDR    = 6'h1B;
  localparam logic [5:0] OP_LB     = 6'h20;
  localparam logic [5:0] OP_LH     = 6'h21;
  localparam logic [5:0] OP_LW     = 6'h23;
  localparam logic [5:0] OP_LBU    = 6'h24;
  localparam logic [5:0] OP_LHU    = 6'h25;
  localparam logic [5:0] OP_LWU    = 6'h27;
  localparam logic [5:0] OP_SB     = 6'h28;
  localparam logic [5:0] OP_SH     = 6'h29;
  localparam logic [5:0] OP_SW     = 6'h2B;
  localparam logic [5:0] OP_SDL    = 6'h2C;
  localparam logic [5:0] OP_SDR    = 6'h2D;
  localparam logic [5:0] OP_CACHE  = 6'h2F;
  localparam logic [5:0] OP_LD     = 6'h37;
  localparam logic [5:0] OP_SD     = 6'h3F;

  localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;
  localparam logic [31:0] DWORD_ADDR_MASK  = 32'hFFFF_FFF8;
  localparam logic [4:0]  REG_RA           = 5'd31;
  localparam logic [63:0] LDL_KEEP_MASK    = 64'h00FF_FFFF_FFFF_FFFF;

  localparam int unsigned IN_DATA_W  = 256;
  localparam int unsigned OUT_DATA_W = 216;

  typedef enum logic [3:0] {
    K_NONE = 4'd0,
    K_LB   = 4'd1,
    K_LBU  = 4'd2,
    K_LH   = 4'd3,
    K_LHU  = 4'd4,
    K_LW   = 4'd5,
    K_LWU  = 4'd6,
    K_LD   = 4'd7,
    K_LDL  = 4'd8,
    K_LDR  = 4'd9
  } load_kind_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] instr_word;
    logic [31:0] pc_value;
    logic [63:0] rs_value;
    logic [63:0] rt_value;
    logic [63:0] load_data;
  } item_t;

  typedef struct packed {
    logic        reg_write;
    logic [4:0]  reg_dest;
    logic [63:0] reg_value;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic        skip_slot;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [7:0]  byte_enable;
    logic [63:0] mem_write_data;
    logic        unsupported;
  } result_t;

  typedef struct packed {
    load_kind_e  kind;
    logic [4:0]  dest;
    logic [2:0]  offset;
    logic [63:0] merge;
  } pend_t;

endpackage

### src/mpoe_exec.sv
// combinational execute logic: alu, branch, memory request and load completion
module mpoe_exec import mpoe_pkg::*; (
  input  item_t   item_i,
  input  pend_t   pend_i,
  output result_t res_o,
  output pend_t   pend_o
);

  logic [5:0]  op;
  logic [4:0]  rtn;
  logic [15:0] imm;
  logic [63:0] simm;
  logic [63:0] imm_z;
  logic [31:0] addr;
  logic [2:0]  k;
  logic [5:0]  ssh;
  logic [31:0] pc4;
  logic [31:0] btarget;
  logic [31:0] jtarget;
  logic [63:0] sum;
  logic        is_cond;
  logic        cond_hit;
  logic        likely;
  logic        is_load;
  load_kind_e  ld_kind;
  logic [2:0]  ld_off;
  logic        is_store;
  logic [7:0]  st_en;
  logic [63:0] st_data;
  logic        wr_en;
  logic [4:0]  wr_dest;
  logic [63:0] wr_val;
  logic        unsup;
  logic [5:0]  lsh;
  logic [63:0] x;
  logic [63:0] ld_val;
  logic        ld_ok;

  always_comb begin
    op      = item_i.instr_word[31:26];
    rtn     = item_i.instr_word[20:16];
    imm     = item_i.instr_word[15:0];
    simm    = {{48{imm[15]}}, imm};
    imm_z   = {48'd0, imm};
    addr    = item_i.rs_value[31:0] + simm[31:0];
    k       = addr[2:0];
    ssh     = {k, 3'b000};
    pc4     = item_i.pc_value + 32'd4;
    btarget = pc4 + {simm[29:0], 2'b00};
    jtarget = (pc4 & JUMP_REGION_MASK) | {4'd0, item_i.instr_word[25:0], 2'b00};
    sum     = item_i.rs_value + simm;

    is_cond  = 1'b0;
    cond_hit = 1'b0;
    likely   = 1'b0;
    is_load  = 1'b0;
    ld_kind  = K_NONE;
    ld_off   = 3'd0;
    is_store = 1'b0;
    st_en    = 8'd0;
    st_data  = '0;
    wr_en    = 1'b0;
    wr_dest  = 5'd0;
    wr_val   = '0;
    unsup    = 1'b0;
    res_o    = '0;
    pend_o   = pend_i;

    // extraction of a returned doubleword
    lsh    = {pend_i.offset, 3'b000};
    x      = item_i.load_data >> lsh;
    ld_ok  = 1'b1;
    ld_val = '0;
    unique case (pend_i.kind)
      K_LB:    ld_val = {{56{x[7]}}, x[7:0]};
      K_LBU:   ld_val = {56'd0, x[7:0]};
      K_LH:    ld_val = {{48{x[15]}}, x[15:0]};
      K_LHU:   ld_val = {48'd0, x[15:0]};
      K_LW:    ld_val = {{32{x[31]}}, x[31:0]};
      K_LWU:   ld_val = {32'd0, x[31:0]};
      K_LD:    ld_val = item_i.load_data;
      K_LDL:   ld_val = (pend_i.merge & (LDL_KEEP_MASK >> lsh))
                      | (item_i.load_data << (6'd56 - lsh));
      K_LDR:   ld_val = (pend_i.merge & ~({64{1'b1}} >> lsh)) | x;
      default: ld_ok  = 1'b0;
    endcase

    if (item_i.req_type) begin
      if (ld_ok) begin
        wr_en       = 1'b1;
        wr_dest     = pend_i.dest;
        wr_val      = ld_val;
        pend_o.kind = K_NONE;
      end else begin
        unsup = 1'b1;
      end
    end else begin
      unique case (op)
        OP_J: begin
          res_o.branch_taken = 1'b1;
          res_o.next_pc      = jtarget;
        end
        OP_JAL: begin
          wr_en              = 1'b1;
          wr_dest            = REG_RA;
          wr_val             = {32'd0, item_i.pc_value + 32'd8};
          res_o.branch_taken = 1'b1;
          res_o.next_pc      = jtarget;
        end
        OP_BEQ: begin
          is_cond  = 1'b1;
          cond_hit = item_i.rs_value == item_i.rt_value;
        end
        OP_BNE: begin
          is_cond  = 1'b1;
          cond_hit = item_i.rs_value != item_i.rt_value;
        end
        OP_BLEZ: begin
          is_cond  = 1'b1;
          cond_hit = item_i.rs_value[63] || (item_i.rs_value == 64'd0);
        end
        OP_BGTZ: begin
          is_cond  = 1'b1;
          cond_hit = !item_i.rs_value[63] && (item_i.rs_value != 64'd0);
        end
        OP_BEQL: begin
          is_cond  = 1'b1;
          likely   = 1'b1;
          cond_hit = item_i.rs_value == item_i.rt_value;
        end
        OP_BNEL: begin
          is_cond  = 1'b1;
          likely   = 1'b1;
          cond_hit = item_i.rs_value != item_i.rt_value;
        end
        OP_ADDIU: begin
          wr_en  = 1'b1;
          wr_val = {{32{sum[31]}}, sum[31:0]};
        end
        OP_SLTI: begin
          wr_en  = 1'b1;
          wr_val = {63'd0, $signed(item_i.rs_value) < $signed(simm)};
        end
        OP_SLTIU: begin
          wr_en  = 1'b1;
          wr_val = {63'd0, item_i.rs_value < simm};
        end
        OP_ANDI: begin
          wr_en  = 1'b1;
          wr_val = item_i.rs_value & imm_z;
        end
        OP_ORI: begin
          wr_en  = 1'b1;
          wr_val = item_i.rs_value | imm_z;
        end
        OP_XORI: begin
          wr_en  = 1'b1;
          wr_val = item_i.rs_value ^ imm_z;
        end
        OP_LUI: begin
          wr_en  = 1'b1;
          wr_val = {{32{imm[15]}}, imm, 16'd0};
        end
        OP_DADDIU: begin
          wr_en  = 1'b1;
          wr_val = sum;
        end
        OP_LDL: begin
          is_load = 1'b1;
          ld_kind = K_LDL;
        end
        OP_LDR: begin
          is_load = 1'b1;
          ld_kind = K_LDR;
        end
        OP_LB: begin
          is_load = 1'b1;
          ld_kind = K_LB;
        end
        OP_LH: begin
          is_load = 1'b1;
          ld_kind = K_LH;
        end
        OP_LW: begin
          is_load = 1'b1;
          ld_kind = K_LW;
        end
        OP_LBU: begin
          is_load = 1'b1;
          ld_kind = K_LBU;
        end
        OP_LHU: begin
          is_load = 1'b1;
          ld_kind = K_LHU;
        end
        OP_LWU: begin
          is_load = 1'b1;
          ld_kind = K_LWU;
        end
        OP_LD: begin
          is_load = 1'b1;
          ld_kind = K_LD;
        end
        OP_SB: begin
          is_store = 1'b1;
          st_en    = 8'h01 << k;
          st_data  = {56'd0, item_i.rt_value[7:0]} << ssh;
        end
        OP_SH: begin
          is_store = 1'b1;
          st_en    = 8'h03 << {k[2:1], 1'b0};
          st_data  = {48'd0, item_i.rt_value[15:0]} << {k[2:1], 4'b0000};
        end
        OP_SW: begin
          is_store = 1'b1;
          st_en    = 8'h0F << {k[2], 2'b00};
          st_data  = {32'd0, item_i.rt_value[31:0]} << {k[2], 5'b00000};
        end
        OP_SD: begin
          is_store = 1'b1;
          st_en    = 8'hFF;
          st_data  = item_i.rt_value;
        end
        OP_SDL: begin
          is_store = 1'b1;
          st_en    = 8'hFF >> (3'd7 - k);
          st_data  = item_i.rt_value >> (6'd56 - ssh);
        end
        OP_SDR: begin
          is_store = 1'b1;
          st_en    = 8'hFF << k;
          st_data  = item_i.rt_value << ssh;
        end
        OP_CACHE: begin
        end
        default: unsup = 1'b1;
      endcase

      if (is_load) begin
        // sub-doubleword accesses ignore the low address bits below their size
        unique case (ld_kind) inside
          K_LH, K_LHU: ld_off = {k[2:1], 1'b0};
          K_LW, K_LWU: ld_off = {k[2], 2'b00};
          K_LD:        ld_off = 3'd0;
          default:     ld_off = k;
        endcase
        pend_o.kind   = ld_kind;
        pend_o.dest   = rtn;
        pend_o.offset = ld_off;
        pend_o.merge  = item_i.rt_value;
        wr_dest       = rtn;
      end else if (!(op == OP_JAL)) begin
        wr_dest = rtn;
      end
    end

    if (is_cond && cond_hit) begin
      res_o.branch_taken = 1'b1;
      res_o.next_pc      = btarget;
    end else if (is_cond && likely) begin
      res_o.skip_slot = 1'b1;
    end

    res_o.reg_write      = wr_en;
    res_o.reg_dest       = wr_en ? wr_dest : 5'd0;
    res_o.reg_value      = wr_val;
    res_o.mem_read       = is_load;
    res_o.mem_write      = is_store;
    res_o.mem_address    = (is_load || is_store) ? (addr & DWORD_ADDR_MASK) : 32'd0;
    res_o.byte_enable    = st_en;
    res_o.mem_write_data = st_data;
    res_o.unsupported    = unsup;
  end

endmodule

### src/mpoe_pend.sv
// pending-load state: kind, destination, byte offset and merge base
module mpoe_pend import mpoe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  upd_i,
  input  pend_t pend_i,
  output pend_t pend_o
);

  pend_t pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '{kind: K_NONE, dest: 5'd0, offset: 3'd0, merge: 64'd0};
    end else if (upd_i) begin
      pend_q <= pend_i;
    end
  end

  assign pend_o = pend_q;

endmodule

### src/mips64_primary_opcode_execute.sv
// execute unit for 64-bit mips primary opcodes: top level with beat pipeline
// Input stream s_axis: one beat is either an instruction (tuser 0) with its word,
// pc and rs/rt values, or a load return (tuser 1) carrying the read doubleword.
// Output stream m_axis: one result beat per input beat, in order, holding the
// writeback, branch/jump outcome, memory read or byte-enabled write request.
// A load beat issues the aligned read and records the pending load; the later
// load-return beat extracts, extends or merges the data and writes it back.
// The input beat is registered in one input register, passes the execute logic
// and is registered in one result register. Throughput is one beat per cycle
// while m_axis_tready stays high; the pending-load state is updated as each beat
// moves into the result register, so a return may directly follow its load.
// Reset clears both pipeline valids and the pending-load state (no load pending).
// When m_axis_tready is low the result register holds, the input register still
// takes one more beat, and s_axis_tready drops only once both are occupied.
module mips64_primary_opcode_execute import mpoe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // instr_word[31:0], pc_value[63:32], rs_value[127:64], rt_value[191:128],
  // load_data[255:192]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // reg_write[0], reg_dest[5:1], reg_value[69:6], branch_taken[70],
  // next_pc[102:71], skip_slot[103], mem_read[104], mem_write[105],
  // mem_address[137:106], byte_enable[145:138], mem_write_data[209:146],
  // unsupported[210], zero pad[215:211]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  `include "mips64_primary_opcode_execute_macros.svh"

  logic    in_valid_q;
  logic    in_valid_d;
  item_t   in_item_q;
  item_t   in_item_d;
  logic    out_valid_q;
  logic    out_valid_d;
  result_t out_res_q;
  result_t out_res_d;
  logic    out_free;
  logic    advance;
  logic    in_take;
  pend_t   pend_q;
  pend_t   pend_d;
  result_t exec_res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  mpoe_exec u_exec (
    .item_i (in_item_q),
    .pend_i (pend_q),
    .res_o  (exec_res),
    .pend_o (pend_d)
  );

  mpoe_pend u_pend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (advance),
    .pend_i (pend_d),
    .pend_o (pend_q)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (in_take) begin
      in_valid_d           = 1'b1;
      in_item_d.req_type   = s_axis_tuser;
      in_item_d.instr_word = s_axis_tdata[31:0];
      in_item_d.pc_value   = s_axis_tdata[63:32];
      in_item_d.rs_value   = s_axis_tdata[127:64];
      in_item_d.rt_value   = s_axis_tdata[191:128];
      in_item_d.load_data  = s_axis_tdata[255:192];
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_res_d   = exec_res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0,
                          out_res_q.unsupported,
                          out_res_q.mem_write_data,
                          out_res_q.byte_enable,
                          out_res_q.mem_address,
                          out_res_q.mem_write,
                          out_res_q.mem_read,
                          out_res_q.skip_slot,
                          out_res_q.next_pc,
                          out_res_q.branch_taken,
                          out_res_q.reg_value,
                          out_res_q.reg_dest,
                          out_res_q.reg_write};

  `MPOE_ASSERT_IMPL(a_rd_wr_excl, out_valid_q,
    !(out_res_q.mem_read && out_res_q.mem_write), "read and write requested together")
  `MPOE_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q,
    "input beat dropped while result stalled")
  `MPOE_ASSERT_NEXT(a_ret_clears, advance && in_item_q.req_type && !exec_res.unsupported,
    pend_q.kind == K_NONE, "completed load left pending")
  `MPOE_ASSERT_IMPL(a_ready_low, !s_axis_tready, in_valid_q && out_valid_q && !m_axis_tready,
    "input stalled without a full pipeline")

endmodule

### tb/mips64_primary_opcode_execute_tb.sv
// self-checking stream testbench for the mips64 primary opcode execute unit
module mips64_primary_opcode_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpoe_pkg::*;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_LQ      = 6'h1E;
  localparam logic [5:0] OP_SQ      = 6'h1F;
  localparam int NUM_OPS     = 32;
  localparam int NUM_LOADS   = 9;
  localparam int HOLD_LEN    = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  mips64_primary_opcode_execute dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  result_t    expected_results[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         tx_gap_pct = 0;
  int         rx_stall_pct = 0;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;

  // predictor copy of the pending-load state
  load_kind_e  pend_kind = K_NONE;
  logic [4:0]  pend_dest = '0;
  logic [2:0]  pend_off = '0;
  logic [63:0] pend_merge = '0;

  function automatic logic [5:0] op_at(int i);
    case (i)
      0:  return OP_J;
      1:  return OP_JAL;
      2:  return OP_BEQ;
      3:  return OP_BNE;
      4:  return OP_BLEZ;
      5:  return OP_BGTZ;
      6:  return OP_ADDIU;
      7:  return OP_SLTI;
      8:  return OP_SLTIU;
      9:  return OP_ANDI;
      10: return OP_ORI;
      11: return OP_XORI;
      12: return OP_LUI;
      13: return OP_BEQL;
      14: return OP_BNEL;
      15: return OP_DADDIU;
      16: return OP_SB;
      17: return OP_SH;
      18: return OP_SW;
      19: return OP_SDL;
      20: return OP_SDR;
      21: return OP_CACHE;
      22: return OP_SD;
      23: return OP_LDL;
      24: return OP_LDR;
      25: return OP_LB;
      26: return OP_LH;
      27: return OP_LW;
      28: return OP_LBU;
      29: return OP_LHU;
      30: return OP_LWU;
      default: return OP_LD;
    endcase
  endfunction

  function automatic bit is_load(logic [5:0] op);
    case (op)
      OP_LDL, OP_LDR, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_LWU, OP_LD: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [63:0] pick64(int sel);
    case (sel)
      0: return 64'h0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return 64'h0000_0000_FFFF_FFFF;
      5: return 64'h1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return pick64($urandom_range(11));
  endfunction

  function automatic logic [15:0] pick16(int sel);
    logic [31:0] r;
    r = $urandom;
    case (sel)
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic [31:0] mk_iw(logic [5:0] op);
    logic [31:0] r;
    r = $urandom;
    return {op, r[25:16], pick16($urandom_range(7))};
  endfunction

  function automatic item_t mk_exec(logic [31:0] iw, logic [31:0] pc, logic [63:0] rs,
                                    logic [63:0] rt);
    item_t it;
    it.req_type   = 1'b0;
    it.instr_word = iw;
    it.pc_value   = pc;
    it.rs_value   = rs;
    it.rt_value   = rt;
    it.load_data  = rand64();
    return it;
  endfunction

  function automatic item_t mk_return(logic [63:0] data);
    item_t it;
    it.req_type   = 1'b1;
    it.instr_word = $urandom;
    it.pc_value   = $urandom;
    it.rs_value   = rand64();
    it.rt_value   = rand64();
    it.load_data  = data;
    return it;
  endfunction

  function automatic item_t rand_nonload();
    logic [5:0]  op;
    logic [63:0] rs;
    logic [31:0] pc;
    do op = op_at($urandom_range(NUM_OPS - 1)); while (is_load(op));
    rs = rand64();
    pc = ($urandom_range(15) == 0) ? 32'hFFFF_FFFC : $urandom;
    return mk_exec(mk_iw(op), pc, rs, ($urandom_range(9) < 3) ? rs : rand64());
  endfunction

  // expected outcome of one beat; advances the predictor's pending-load state
  function automatic result_t predict_execute(item_t it);
    result_t     r;
    logic [5:0]  op;
    logic [4:0]  rtn;
    logic [63:0] imm, simm, sum, x, v, wd;
    logic [31:0] addr, btgt, jtgt;
    logic [2:0]  k;
    logic [5:0]  sh;
    logic [7:0]  be;
    load_kind_e  lk;
    bit          is_store, likely;
    int          cond;
    r = '0;
    if (it.req_type) begin
      sh = {pend_off, 3'b000};
      x  = it.load_data >> sh;
      v  = '0;
      case (pend_kind)
        K_LB:  v = {{56{x[7]}}, x[7:0]};
        K_LBU: v = {56'b0, x[7:0]};
        K_LH:  v = {{48{x[15]}}, x[15:0]};
        K_LHU: v = {48'b0, x[15:0]};
        K_LW:  v = {{32{x[31]}}, x[31:0]};
        K_LWU: v = {32'b0, x[31:0]};
        K_LD:  v = it.load_data;
        K_LDL: v = (pend_merge & (LDL_KEEP_MASK >> sh)) | (it.load_data << (56 - sh));
        K_LDR: v = (pend_merge & ~(64'hFFFF_FFFF_FFFF_FFFF >> sh)) | x;
        default: r.unsupported = 1'b1;
      endcase
      if (pend_kind != K_NONE) begin
        r.reg_write = 1'b1;
        r.reg_dest  = pend_dest;
        r.reg_value = v;
        pend_kind   = K_NONE;
      end
      return r;
    end

    op   = it.instr_word[31:26];
    rtn  = it.instr_word[20:16];
    imm  = {48'b0, it.instr_word[15:0]};
    simm = {{48{it.instr_word[15]}}, it.instr_word[15:0]};
    addr = it.rs_value[31:0] + simm[31:0];
    k    = addr[2:0];
    btgt = it.pc_value + 32'd4 + {simm[29:0], 2'b00};
    jtgt = ((it.pc_value + 32'd4) & JUMP_REGION_MASK) + {4'b0, it.instr_word[25:0], 2'b00};
    cond = -1;
    likely = 1'b0;
    lk = K_NONE;
    is_store = 1'b0;
    be = '0;
    wd = '0;
    sum = it.rs_value + simm;

    case (op)
      OP_J: begin
        r.branch_taken = 1'b1;
        r.next_pc      = jtgt;
      end
      OP_JAL: begin
        r.reg_write    = 1'b1;
        r.reg_dest     = REG_RA;
        r.reg_value    = {32'b0, it.pc_value + 32'd8};
        r.branch_taken = 1'b1;
        r.next_pc      = jtgt;
      end
      OP_BEQ:  cond = (it.rs_value == it.rt_value);
      OP_BNE:  cond = (it.rs_value != it.rt_value);
      OP_BLEZ: cond = ($signed(it.rs_value) <= 0);
      OP_BGTZ: cond = ($signed(it.rs_value) > 0);
      OP_BEQL: begin
        cond = (it.rs_value == it.rt_value);
        likely = 1'b1;
      end
      OP_BNEL: begin
        cond = (it.rs_value != it.rt_value);
        likely = 1'b1;
      end
      OP_ADDIU: begin
        r.reg_write = 1'b1;
        r.reg_value = {{32{sum[31]}}, sum[31:0]};
      end
      OP_SLTI: begin
        r.reg_write = 1'b1;
        r.reg_value = {63'b0, $signed(it.rs_value) < $signed(simm)};
      end
      OP_SLTIU: begin
        r.reg_write = 1'b1;
        r.reg_value = {63'b0, it.rs_value < simm};
      end
      OP_ANDI: begin
        r.reg_write = 1'b1;
        r.reg_value = it.rs_value & imm;
      end
      OP_ORI: begin
        r.reg_write = 1'b1;
        r.reg_value = it.rs_value | imm;
      end
      OP_XORI: begin
        r.reg_write = 1'b1;
        r.reg_value = it.rs_value ^ imm;
      end
      OP_LUI: begin
        r.reg_write = 1'b1;
        r.reg_value = {{32{it.instr_word[15]}}, it.instr_word[15:0], 16'b0};
      end
      OP_DADDIU: begin
        r.reg_write = 1'b1;
        r.reg_value = sum;
      end
      OP_LDL: lk = K_LDL;
      OP_LDR: lk = K_LDR;
      OP_LB:  lk = K_LB;
      OP_LH:  lk = K_LH;
      OP_LW:  lk = K_LW;
      OP_LBU: lk = K_LBU;
      OP_LHU: lk = K_LHU;
      OP_LWU: lk = K_LWU;
      OP_LD:  lk = K_LD;
      OP_SB: begin
        is_store = 1'b1;
        be = 8'h01 << k;
        wd = {56'b0, it.rt_value[7:0]} << {k, 3'b000};
      end
      OP_SH: begin
        is_store = 1'b1;
        be = 8'h03 << (k & 3'd6);
        wd = {48'b0, it.rt_value[15:0]} << {k & 3'd6, 3'b000};
      end
      OP_SW: begin
        is_store = 1'b1;
        be = 8'h0F << (k & 3'd4);
        wd = {32'b0, it.rt_value[31:0]} << {k & 3'd4, 3'b000};
      end
      OP_SD: begin
        is_store = 1'b1;
        be = 8'hFF;
        wd = it.rt_value;
      end
      OP_SDL: begin
        is_store = 1'b1;
        be = 8'hFF >> (7 - k);
        wd = it.rt_value >> (56 - {k, 3'b000});
      end
      OP_SDR: begin
        is_store = 1'b1;
        be = 8'hFF << k;
        wd = it.rt_value << {k, 3'b000};
      end
      OP_CACHE: ;
      default: r.unsupported = 1'b1;
    endcase

    // alu writebacks target rt
    if (r.reg_write && op != OP_JAL) r.reg_dest = rtn;

    if (lk != K_NONE) begin
      case (lk)
        K_LH, K_LHU: pend_off = k & 3'd6;
        K_LW, K_LWU: pend_off = k & 3'd4;
        K_LD:        pend_off = 3'd0;
        default:     pend_off = k;
      endcase
      pend_kind     = lk;
      pend_dest     = rtn;
      pend_merge    = it.rt_value;
      r.mem_read    = 1'b1;
      r.mem_address = addr & DWORD_ADDR_MASK;
    end
    if (is_store) begin
      r.mem_write      = 1'b1;
      r.mem_address    = addr & DWORD_ADDR_MASK;
      r.byte_enable    = be;
      r.mem_write_data = wd;
    end
    if (cond == 1) begin
      r.branch_taken = 1'b1;
      r.next_pc      = btgt;
    end else if (cond == 0 && likely) begin
      r.skip_slot = 1'b1;
    end
    return r;
  endfunction

  task automatic send_beat(item_t it);
    // each idle cycle is drawn on its own so the idle share matches the rate
    while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.req_type;
    s_axis_tdata  <= {it.load_data, it.rt_value, it.rs_value, it.pc_value, it.instr_word};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_execute(it));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [5:0]  op;
    logic [63:0] rs;
    logic [31:0] pc;
    int          i;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    // return with nothing pending right after reset
    send_beat(mk_return(rand64()));
    for (i = 0; i < NUM_OPS; i++) begin
      op = op_at(i);
      rs = pick64(i % 6);
      pc = (i % 3 == 0) ? 32'hFFFF_FFFC : $urandom;
      send_beat(mk_exec({op, i[4:0], i[4:0] ^ 5'd31, pick16(i % 4)}, pc, rs,
                        (i % 2) ? rs : pick64((i + 3) % 6)));
      if (is_load(op)) send_beat(mk_return(pick64(i % 6)));
    end
    send_beat(mk_exec(mk_iw(OP_SPECIAL), $urandom, rand64(), rand64()));
    send_beat(mk_exec(mk_iw(OP_REGIMM), $urandom, rand64(), rand64()));
    send_beat(mk_exec(mk_iw(OP_LQ), $urandom, rand64(), rand64()));
    send_beat(mk_exec(mk_iw(OP_SQ), $urandom, rand64(), rand64()));
    // second load replaces the first before its return
    send_beat(mk_exec(mk_iw(OP_LB), $urandom, rand64(), rand64()));
    send_beat(mk_exec(mk_iw(OP_LDL), $urandom, rand64(), rand64()));
    send_beat(mk_return(rand64()));
    send_beat(mk_return(rand64()));
    wait_drained();
  endtask

  task automatic test_backpressure();
    int i;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    hold_requests++;
    for (i = 0; i < 24; i++) begin
      case (i % 3)
        0: send_beat(mk_exec(mk_iw(op_at(23 + $urandom_range(NUM_LOADS - 1))), $urandom,
                             rand64(), rand64()));
        1: send_beat(rand_nonload());
        default: send_beat(mk_return(rand64()));
      endcase
    end
    wait_drained();
  endtask

  task automatic test_random(int n_items, int gap_pct, int stall_pct);
    int sent;
    int fill;
    int j;
    tx_gap_pct = gap_pct;
    rx_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        // load, up to two unrelated instructions, then its return
        send_beat(mk_exec(mk_iw(op_at(23 + $urandom_range(NUM_LOADS - 1))), $urandom,
                          rand64(), rand64()));
        fill = $urandom_range(2);
        for (j = 0; j < fill; j++) send_beat(rand_nonload());
        send_beat(mk_return(rand64()));
        sent += fill + 2;
      end else begin
        case ($urandom_range(2))
          0: send_beat(mk_return(rand64()));
          1: send_beat(mk_exec($urandom, $urandom, rand64(), rand64()));
          default: send_beat(rand_nonload());
        endcase
        sent++;
      end
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served   <= hold_requests;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.reg_write      = m_axis_tdata[0];
      got.reg_dest       = m_axis_tdata[5:1];
      got.reg_value      = m_axis_tdata[69:6];
      got.branch_taken   = m_axis_tdata[70];
      got.next_pc        = m_axis_tdata[102:71];
      got.skip_slot      = m_axis_tdata[103];
      got.mem_read       = m_axis_tdata[104];
      got.mem_write      = m_axis_tdata[105];
      got.mem_address    = m_axis_tdata[137:106];
      got.byte_enable    = m_axis_tdata[145:138];
      got.mem_write_data = m_axis_tdata[209:146];
      got.unsupported    = m_axis_tdata[210];
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("reg_write", want.reg_write, got.reg_write);
        check_field("reg_dest", want.reg_dest, got.reg_dest);
        check_field("reg_value", want.reg_value, got.reg_value);
        check_field("branch_taken", want.branch_taken, got.branch_taken);
        check_field("next_pc", want.next_pc, got.next_pc);
        check_field("skip_slot", want.skip_slot, got.skip_slot);
        check_field("mem_read", want.mem_read, got.mem_read);
        check_field("mem_write", want.mem_write, got.mem_write);
        check_field("mem_address", want.mem_address, got.mem_address);
        check_field("byte_enable", want.byte_enable, got.byte_enable);
        check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
        check_field("unsupported", want.unsupported, got.unsupported);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(375, 0, 0);
    test_random(375, 45, 0);
    test_random(375, 0, 45);
    test_random(375, 8, 8);
    rx_stall_pct = 0;
    // wait past the two-stage pipeline to catch stray beats
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/mpoe_pkg.sv
src/mpoe_exec.sv
src/mpoe_pend.sv
src/mips64_primary_opcode_execute.sv
tb/mips64_primary_opcode_execute_tb.sv
